[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sine/cosine pipeline.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge while reset is low.
`define ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property at every rising edge, reset cycles included.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/sct_pkg.sv]
// ---------------------------------------------------------------------------
// sct_pkg
// Widths, fixed-point constants and the sine/cosine sample tables, all
// worked out at elaboration.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sct_pkg;

   // Table geometry: 2**TABLE_LOG2 intervals, one extra point at a full turn
   localparam int TABLE_LOG2      = 6;
   localparam int TABLE_INTERVALS = 1 << TABLE_LOG2;
   localparam int TABLE_POINTS    = TABLE_INTERVALS + 1;
   localparam int INDEX_W         = TABLE_LOG2 + 1;

   // Field and bus widths
   localparam int ANGLE_W    = 32;
   localparam int RESULT_W   = 18;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = ((2 * RESULT_W + 7) / 8) * 8;

   // Turn product: angle times 1/(2*pi) in units of 2**-64 of a turn
   localparam int TURN_W   = 64;
   localparam int FRAC_W   = 24;
   localparam int FRAC_LSB = TURN_W - FRAC_W;
   localparam int KTURN_W  = 38;
   localparam int K_SPLIT  = 19;

   // Residual angle datapath
   localparam int MAG_W    = FRAC_W;
   localparam int TWO_PI_W = 33;
   localparam int PROD_W   = MAG_W + TWO_PI_W;
   localparam int DMAG_W   = 32 - TABLE_LOG2;

   // Taylor step datapath
   localparam int SAMPLE_W = 32;
   localparam int Q30_FB   = 30;
   localparam int SQ_W     = 2 * DMAG_W;
   localparam int SQ_SHIFT = 31;
   localparam int D2H_W    = SQ_W - SQ_SHIFT;
   localparam int DPROD_W  = DMAG_W + 1 + SAMPLE_W;
   localparam int HPROD_W  = D2H_W + 1 + SAMPLE_W;
   localparam int SUM_W    = 64;
   localparam int Q16_SHIFT = 44;

   localparam logic [63:0] ONE_E18    = 64'd1000000000000000000;
   localparam logic [63:0] TWO_PI_E18 = 64'd6283185307179586477;
   localparam logic [63:0] Q30_ONE    = 64'd1 << Q30_FB;

   typedef logic [TABLE_POINTS-1:0][SAMPLE_W-1:0] sample_tab_type;

   // Word handed from the residual stage to the Taylor stage
   typedef struct packed {
      logic                       neg;
      logic [DMAG_W-1:0]          dmag;
      logic signed [SAMPLE_W-1:0] ts;
      logic signed [SAMPLE_W-1:0] tc;
   } taylor_in_type;

   // floor(num * 2**bits / den) by restoring long division
   function automatic logic [63:0] scaled_ratio(logic [63:0] num, logic [63:0] den, int bits);
      logic [64:0] rem;
      logic [63:0] quo;
      logic [63:0] src;
      rem = '0;
      quo = '0;
      src = num;
      for (int k = 0; k < 64 + bits; k++) begin
         rem = {rem[63:0], src[63]};
         src = {src[62:0], 1'b0};
         quo = {quo[62:0], 1'b0};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[0] = 1'b1;
         end
      end
      return quo;
   endfunction

   localparam logic [63:0] K_TURN      = (scaled_ratio(ONE_E18, TWO_PI_E18, 41) + 64'd1) >> 1;
   localparam logic [63:0] TWO_PI_Q30  = (scaled_ratio(TWO_PI_E18, ONE_E18, 31) + 64'd1) >> 1;
   localparam logic [63:0] HALF_PI_Q30 =
      (scaled_ratio(TWO_PI_E18, 64'd4 * ONE_E18, 31) + 64'd1) >> 1;

   // sin and cos on the quarter wave, Q30, by a 13-term Taylor series
   function automatic logic [1:0][63:0] quarter_wave(logic [63:0] a);
      logic [63:0]        tsn;
      logic [63:0]        tcn;
      logic [63:0]        kk;
      logic signed [63:0] ss;
      logic signed [63:0] cc;
      tsn = a;
      tcn = Q30_ONE;
      ss  = signed'(a);
      cc  = signed'(Q30_ONE);
      for (int k = 1; k <= 12; k++) begin
         kk  = 64'(k);
         // Next series terms, each divided by its factorial step
         tcn = scaled_ratio((((tcn * a) >> 30) * a) >> 30,
                            (64'd2 * kk - 64'd1) * (64'd2 * kk), 0);
         tsn = scaled_ratio((((tsn * a) >> 30) * a) >> 30,
                            (64'd2 * kk) * (64'd2 * kk + 64'd1), 0);
         if (kk[0]) begin
            cc = cc - signed'(tcn);
            ss = ss - signed'(tsn);
         end else begin
            cc = cc + signed'(tcn);
            ss = ss + signed'(tsn);
         end
      end
      if (ss < 0) ss = 0;
      if (ss > signed'(Q30_ONE)) ss = signed'(Q30_ONE);
      if (cc < 0) cc = 0;
      if (cc > signed'(Q30_ONE)) cc = signed'(Q30_ONE);
      return {cc, ss};
   endfunction

   // Sample table at every point of the turn, sine or cosine, Q30
   function automatic sample_tab_type build_table(logic want_cos);
      sample_tab_type     tab;
      logic [63:0]        m;
      logic [63:0]        quad;
      logic [63:0]        rem;
      logic [63:0]        a;
      logic [1:0][63:0]   qw;
      logic signed [63:0] qs;
      logic signed [63:0] qc;
      logic signed [63:0] vs;
      logic signed [63:0] vc;
      tab = '0;
      for (int i = 0; i < TABLE_POINTS; i++) begin
         m    = 64'd4 * 64'(i);
         quad = (m / 64'(TABLE_INTERVALS)) & 64'd3;
         rem  = m % 64'(TABLE_INTERVALS);
         a    = (rem * HALF_PI_Q30 + 64'(TABLE_INTERVALS / 2)) / 64'(TABLE_INTERVALS);
         qw   = quarter_wave(a);
         qs   = signed'(qw[0]);
         qc   = signed'(qw[1]);
         unique case (quad[1:0])
            2'd0: begin
               vs = qs;
               vc = qc;
            end
            2'd1: begin
               vs = qc;
               vc = -qs;
            end
            2'd2: begin
               vs = -qs;
               vc = -qc;
            end
            2'd3: begin
               vs = -qc;
               vc = qs;
            end
         endcase
         tab[i] = want_cos ? vc[SAMPLE_W-1:0] : vs[SAMPLE_W-1:0];
      end
      return tab;
   endfunction

   localparam sample_tab_type SIN_TAB = build_table(1'b0);
   localparam sample_tab_type COS_TAB = build_table(1'b1);

endpackage

`default_nettype wire

[design/sct_turn.sv]
// ---------------------------------------------------------------------------
// sct_turn
// Scales the Q8.24 angle by 1/(2*pi) and keeps the 24-bit fractional turn.
// Two stages: split partial products, then their sum.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sct_turn (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic [sct_pkg::ANGLE_W-1:0]  in_angle,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output logic [sct_pkg::FRAC_W-1:0]        out_frac
);
   import sct_pkg::*;

   localparam int KHI_W = KTURN_W - K_SPLIT;
   localparam int PP_W  = ANGLE_W + K_SPLIT + 1;
   localparam logic [K_SPLIT-1:0] K_LO = K_TURN[K_SPLIT-1:0];
   localparam logic [KHI_W-1:0]   K_HI = K_TURN[KTURN_W-1:K_SPLIT];

   logic                   rdy1;
   logic                   rdy2;
   logic                   v1_ff;
   logic                   v1_in;
   logic                   v2_ff;
   logic                   v2_in;
   logic signed [PP_W-1:0] pp_lo_ff;
   logic signed [PP_W-1:0] pp_lo_in;
   logic signed [PP_W-1:0] pp_hi_ff;
   logic signed [PP_W-1:0] pp_hi_in;
   logic [TURN_W-1:0]      turn;
   logic [FRAC_W-1:0]      frac_ff;
   logic [FRAC_W-1:0]      frac_in;

   // Advance a stage when it is empty or its word moves on
   assign rdy2     = !v2_ff || out_ready;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // Stage 1: angle times each half of the turn constant
   always_comb begin
      v1_in    = rdy1 ? in_valid : v1_ff;
      pp_lo_in = rdy1 ? $signed(in_angle) * $signed({1'b0, K_LO}) : pp_lo_ff;
      pp_hi_in = rdy1 ? $signed(in_angle) * $signed({1'b0, K_HI}) : pp_hi_ff;
   end

   // Stage 2: recombine modulo one turn, keep the fraction
   always_comb begin
      turn = {{(TURN_W - PP_W){pp_lo_ff[PP_W-1]}}, pp_lo_ff}
           + ({{(TURN_W - PP_W){pp_hi_ff[PP_W-1]}}, pp_hi_ff} << K_SPLIT);
      v2_in   = rdy2 ? v1_ff : v2_ff;
      frac_in = rdy2 ? turn[FRAC_LSB +: FRAC_W] : frac_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      pp_lo_ff <= pp_lo_in;
      pp_hi_ff <= pp_hi_in;
      frac_ff  <= frac_in;
   end

   assign out_valid = v2_ff;
   assign out_frac  = frac_ff;

endmodule

`default_nettype wire

[design/sct_resid.sv]
// ---------------------------------------------------------------------------
// sct_resid
// Rounds the turn fraction to the nearest table point, scales the residual
// to radians in Q30 and fetches the table samples. Two stages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sct_resid (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire logic [sct_pkg::FRAC_W-1:0]  in_frac,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output sct_pkg::taylor_in_type           out_word
);
   import sct_pkg::*;

   localparam int DIV_SHIFT = FRAC_W + TABLE_LOG2;
   localparam logic [TWO_PI_W-1:0] TWO_PI_K   = TWO_PI_Q30[TWO_PI_W-1:0];
   localparam logic [PROD_W:0]     DMAG_ROUND = (PROD_W + 1)'(1) << (DIV_SHIFT - 1);
   localparam logic [INDEX_W-1:0]  LAST_INDEX = INDEX_W'(TABLE_INTERVALS);

   logic                rdy1;
   logic                rdy2;
   logic                v1_ff;
   logic                v1_in;
   logic                v2_ff;
   logic                v2_in;
   logic [FRAC_W-1:0]   low;
   logic [MAG_W-1:0]    mag;
   logic [INDEX_W-1:0]  idx;
   logic [INDEX_W-1:0]  idx1_ff;
   logic [INDEX_W-1:0]  idx1_in;
   logic                neg1_ff;
   logic                neg1_in;
   logic [PROD_W-1:0]   prod1_ff;
   logic [PROD_W-1:0]   prod1_in;
   logic [PROD_W:0]     rnd_sum;
   taylor_in_type       word_ff;
   taylor_in_type       word_in;

   assign rdy2     = !v2_ff || out_ready;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // Stage 1: nearest point (half rounds up), residual magnitude times 2*pi
   always_comb begin
      low      = {in_frac[FRAC_W-TABLE_LOG2-1:0], {TABLE_LOG2{1'b0}}};
      idx      = {1'b0, in_frac[FRAC_W-1 -: TABLE_LOG2]} + INDEX_W'(low[FRAC_W-1]);
      mag      = low[FRAC_W-1] ? MAG_W'(-low) : low;
      v1_in    = rdy1 ? in_valid : v1_ff;
      idx1_in  = rdy1 ? idx : idx1_ff;
      neg1_in  = rdy1 ? low[FRAC_W-1] : neg1_ff;
      prod1_in = rdy1 ? mag * TWO_PI_K : prod1_ff;
   end

   // Stage 2: round to Q30 radians, look up the samples
   always_comb begin
      rnd_sum = {1'b0, prod1_ff} + DMAG_ROUND;
      v2_in   = rdy2 ? v1_ff : v2_ff;
      word_in = word_ff;
      if (rdy2) begin
         word_in.neg  = neg1_ff;
         word_in.dmag = rnd_sum[DIV_SHIFT +: DMAG_W];
         word_in.ts   = $signed(SIN_TAB[idx1_ff]);
         word_in.tc   = $signed(COS_TAB[idx1_ff]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff  <= idx1_in;
      neg1_ff  <= neg1_in;
      prod1_ff <= prod1_in;
      word_ff  <= word_in;
   end

   assign out_valid = v2_ff;
   assign out_word  = word_ff;

   `ASSERT_CLK(a_index_range, clock, reset, v1_ff |-> (idx1_ff <= LAST_INDEX), "table index past last point")

endmodule

`default_nettype wire

[design/sct_taylor.sv]
// ---------------------------------------------------------------------------
// sct_taylor
// Second-order Taylor step around the table samples, rounding to Q2.16
// and saturation. Three stages: first products, second products, sums.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sct_taylor (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire sct_pkg::taylor_in_type        in_word,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic signed [sct_pkg::RESULT_W-1:0] out_sin,
   output logic signed [sct_pkg::RESULT_W-1:0] out_cos
);
   import sct_pkg::*;

   localparam logic signed [SUM_W-1:0]    ROUND_Q16 = SUM_W'(1) <<< (Q16_SHIFT - 1);
   localparam logic signed [SUM_W-1:0]    SAT_HI    = SUM_W'(65536);
   localparam logic signed [SUM_W-1:0]    SAT_LO    = -SUM_W'(65536);
   localparam logic signed [RESULT_W-1:0] OUT_HI    = RESULT_W'(65536);
   localparam logic signed [RESULT_W-1:0] OUT_LO    = -RESULT_W'(65536);

   // Round a Q60 sum to Q16 (half up) and clamp to plus or minus one
   function automatic logic signed [RESULT_W-1:0] sat_q16(logic signed [SUM_W-1:0] sum);
      logic signed [SUM_W-1:0] sh;
      sh = (sum + ROUND_Q16) >>> Q16_SHIFT;
      if (sh > SAT_HI) begin
         return OUT_HI;
      end else if (sh < SAT_LO) begin
         return OUT_LO;
      end
      return sh[RESULT_W-1:0];
   endfunction

   // Sign-extend a sample, scaled to Q60
   function automatic logic signed [SUM_W-1:0] q60(logic signed [SAMPLE_W-1:0] v);
      return {{(SUM_W - SAMPLE_W - Q30_FB){v[SAMPLE_W-1]}}, v, {Q30_FB{1'b0}}};
   endfunction

   logic                        rdy1;
   logic                        rdy2;
   logic                        rdy3;
   logic                        v1_ff;
   logic                        v1_in;
   logic                        v2_ff;
   logic                        v2_in;
   logic                        v3_ff;
   logic                        v3_in;
   logic signed [DMAG_W:0]      dsg;
   logic [SQ_W-1:0]             sq1_ff;
   logic [SQ_W-1:0]             sq1_in;
   logic signed [DPROD_W-1:0]   dtc1_ff;
   logic signed [DPROD_W-1:0]   dtc1_in;
   logic signed [DPROD_W-1:0]   dts1_ff;
   logic signed [DPROD_W-1:0]   dts1_in;
   logic signed [SAMPLE_W-1:0]  ts1_ff;
   logic signed [SAMPLE_W-1:0]  ts1_in;
   logic signed [SAMPLE_W-1:0]  tc1_ff;
   logic signed [SAMPLE_W-1:0]  tc1_in;
   logic [D2H_W-1:0]            d2h;
   logic signed [HPROD_W-1:0]   hs2_ff;
   logic signed [HPROD_W-1:0]   hs2_in;
   logic signed [HPROD_W-1:0]   hc2_ff;
   logic signed [HPROD_W-1:0]   hc2_in;
   logic signed [DPROD_W-1:0]   dtc2_ff;
   logic signed [DPROD_W-1:0]   dtc2_in;
   logic signed [DPROD_W-1:0]   dts2_ff;
   logic signed [DPROD_W-1:0]   dts2_in;
   logic signed [SAMPLE_W-1:0]  ts2_ff;
   logic signed [SAMPLE_W-1:0]  ts2_in;
   logic signed [SAMPLE_W-1:0]  tc2_ff;
   logic signed [SAMPLE_W-1:0]  tc2_in;
   logic signed [SUM_W-1:0]     s_sum;
   logic signed [SUM_W-1:0]     c_sum;
   logic signed [RESULT_W-1:0]  sin_ff;
   logic signed [RESULT_W-1:0]  sin_in;
   logic signed [RESULT_W-1:0]  cos_ff;
   logic signed [RESULT_W-1:0]  cos_in;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // Stage 1: d squared, d*tc and d*ts
   always_comb begin
      dsg     = in_word.neg ? -$signed({1'b0, in_word.dmag}) : $signed({1'b0, in_word.dmag});
      v1_in   = rdy1 ? in_valid : v1_ff;
      sq1_in  = rdy1 ? in_word.dmag * in_word.dmag : sq1_ff;
      dtc1_in = rdy1 ? dsg * in_word.tc : dtc1_ff;
      dts1_in = rdy1 ? dsg * in_word.ts : dts1_ff;
      ts1_in  = rdy1 ? in_word.ts : ts1_ff;
      tc1_in  = rdy1 ? in_word.tc : tc1_ff;
   end

   // Stage 2: half of d squared times each sample
   always_comb begin
      d2h     = sq1_ff[SQ_W-1:SQ_SHIFT];
      v2_in   = rdy2 ? v1_ff : v2_ff;
      hs2_in  = rdy2 ? $signed({1'b0, d2h}) * ts1_ff : hs2_ff;
      hc2_in  = rdy2 ? $signed({1'b0, d2h}) * tc1_ff : hc2_ff;
      dtc2_in = rdy2 ? dtc1_ff : dtc2_ff;
      dts2_in = rdy2 ? dts1_ff : dts2_ff;
      ts2_in  = rdy2 ? ts1_ff : ts2_ff;
      tc2_in  = rdy2 ? tc1_ff : tc2_ff;
   end

   // Stage 3: sum in Q60, round and clamp into the output register
   always_comb begin
      s_sum  = q60(ts2_ff)
             + {{(SUM_W - DPROD_W){dtc2_ff[DPROD_W-1]}}, dtc2_ff}
             - {{(SUM_W - HPROD_W){hs2_ff[HPROD_W-1]}}, hs2_ff};
      c_sum  = q60(tc2_ff)
             - {{(SUM_W - DPROD_W){dts2_ff[DPROD_W-1]}}, dts2_ff}
             - {{(SUM_W - HPROD_W){hc2_ff[HPROD_W-1]}}, hc2_ff};
      v3_in  = rdy3 ? v2_ff : v3_ff;
      sin_in = rdy3 ? sat_q16(s_sum) : sin_ff;
      cos_in = rdy3 ? sat_q16(c_sum) : cos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      sq1_ff  <= sq1_in;
      dtc1_ff <= dtc1_in;
      dts1_ff <= dts1_in;
      ts1_ff  <= ts1_in;
      tc1_ff  <= tc1_in;
      hs2_ff  <= hs2_in;
      hc2_ff  <= hc2_in;
      dtc2_ff <= dtc2_in;
      dts2_ff <= dts2_in;
      ts2_ff  <= ts2_in;
      tc2_ff  <= tc2_in;
      sin_ff  <= sin_in;
      cos_ff  <= cos_in;
   end

   assign out_valid = v3_ff;
   assign out_sin   = sin_ff;
   assign out_cos   = cos_ff;

   `ASSERT_CLK(a_out_range, clock, reset, v3_ff |-> (sin_ff >= OUT_LO && sin_ff <= OUT_HI && cos_ff >= OUT_LO && cos_ff <= OUT_HI), "result beyond plus or minus one")

endmodule

`default_nettype wire

[design/sincos_lut_taylor.sv]
// ---------------------------------------------------------------------------
// sincos_lut_taylor
// Sine and cosine of an angle in radians by a 64-interval table and a
// second-order Taylor step.
//
// req channel: one word per angle, signed Q8.24 radians; any 32-bit value
// is valid and whole turns are dropped.
// rsp channel: one word per angle, sine and cosine as signed Q2.16,
// saturated to plus or minus one, in the order the angles arrived.
// Stages: two for the turn scaling, two for the table point and residual,
// three for the Taylor step, between the req handshake and rsp_tvalid.
// Throughput: one word per cycle while rsp_tready is high, set by the
// multipliers, each of which finishes in a single stage.
// Reset clears every stage valid bit; words in flight are dropped.
// Stall: while rsp_tready is low the result holds and the earlier stages
// keep filling their empty slots, so req_tready stays high until all seven
// stages hold a word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sincos_lut_taylor (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [31:0] angle_radians
   input  wire logic [sct_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [17:0] sin_value, [35:18] cos_value, rest zero
   output logic [sct_pkg::RSP_DATA_W-1:0]       rsp_tdata
);
   import sct_pkg::*;

   logic                       turn_valid;
   logic                       turn_ready;
   logic [FRAC_W-1:0]          turn_frac;
   logic                       resid_valid;
   logic                       resid_ready;
   taylor_in_type              resid_word;
   logic signed [RESULT_W-1:0] sin_value;
   logic signed [RESULT_W-1:0] cos_value;

   sct_turn u_turn (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_angle  (req_tdata[ANGLE_W-1:0]),
      .out_valid (turn_valid),
      .out_ready (turn_ready),
      .out_frac  (turn_frac)
   );

   sct_resid u_resid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (turn_valid),
      .in_ready  (turn_ready),
      .in_frac   (turn_frac),
      .out_valid (resid_valid),
      .out_ready (resid_ready),
      .out_word  (resid_word)
   );

   sct_taylor u_taylor (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (resid_valid),
      .in_ready  (resid_ready),
      .in_word   (resid_word),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_sin   (sin_value),
      .out_cos   (cos_value)
   );

   // Pack the result word, sine in the low bits
   assign rsp_tdata = {{(RSP_DATA_W - 2 * RESULT_W){1'b0}}, cos_value, sin_value};

   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result valid right after reset")
   `ASSERT_CLK(a_ready_chain, clock, reset, (!rsp_tvalid || rsp_tready) |-> req_tready, "input blocked with free output slot")

endmodule

`default_nettype wire

[sim/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for sincos_lut_taylor. Angles go in on the req stream,
// and a bit-exact model of the table-plus-Taylor datapath predicts each sine
// and cosine word. Results are compared in arrival order. Both streams idle
// and stall at random in two mixes and run with no idles in a third.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int     N_INTERVALS = 64;
   localparam int     IDLE_LIMIT  = 5000;
   localparam int     TAIL_CYCLES = 20;
   localparam int     PRINT_CAP   = 100;
   localparam int     RANDOM_ITEMS = 342;
   localparam real    TWO_PI_REAL = 6.283185307179586;
   localparam longint Q30_UNIT    = 64'sd1 << 30;
   localparam logic [63:0] ONE_E18    = 64'd1000000000000000000;
   localparam logic [63:0] TWO_PI_E18 = 64'd6283185307179586477;

   typedef struct packed {
      logic [31:0] angle;
      logic [17:0] sin_q16;
      logic [17:0] cos_q16;
   } sincos_word_type;

   logic                               clock      = 1'b0;
   logic                               reset      = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [sct_pkg::REQ_DATA_W-1:0]     req_tdata  = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [sct_pkg::RSP_DATA_W-1:0]     rsp_tdata;

   // Fixed-point constants and Q30 sample tables of the predictor
   logic [63:0] turn_scale;
   logic [63:0] two_pi_q30;
   logic [63:0] half_pi_q30;
   longint      sin_q30 [0:N_INTERVALS];
   longint      cos_q30 [0:N_INTERVALS];

   sincos_word_type pending_results [$];
   sincos_word_type oldest;
   int           send_idle_pct = 25;
   int           rsp_idle_pct  = 60;
   int           mismatch_count = 0;
   int           angles_sent    = 0;
   int           results_seen   = 0;
   int           idle_cycles    = 0;

   sincos_lut_taylor DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // floor(num * 2**bits / den)
   function automatic logic [63:0] floor_ratio(logic [63:0] num, logic [63:0] den, int bits);
      logic [127:0] wide;
      wide = ({64'd0, num} << bits) / {64'd0, den};
      return wide[63:0];
   endfunction

   // Quarter-wave sin and cos in Q30 by a 13-term series, clamped to [0, 1]
   function automatic void quarter_sincos(input logic [63:0] a, output longint s,
                                          output longint c);
      logic [63:0] s_term;
      logic [63:0] c_term;
      s_term = a;
      c_term = 64'(Q30_UNIT);
      s      = longint'(a);
      c      = Q30_UNIT;
      for (int k = 1; k <= 12; k++) begin
         c_term = ((((c_term * a) >> 30) * a) >> 30) / 64'((2 * k - 1) * (2 * k));
         s_term = ((((s_term * a) >> 30) * a) >> 30) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) begin
            c = c - longint'(c_term);
            s = s - longint'(s_term);
         end else begin
            c = c + longint'(c_term);
            s = s + longint'(s_term);
         end
      end
      if (s < 0) s = 0;
      if (s > Q30_UNIT) s = Q30_UNIT;
      if (c < 0) c = 0;
      if (c > Q30_UNIT) c = Q30_UNIT;
   endfunction

   // Q60 sum to Q16, half rounds up, saturate to plus or minus one
   function automatic logic [17:0] q60_to_q16(longint sum);
      longint v;
      v = (sum + (64'sd1 <<< 43)) >>> 44;
      if (v > 65536) v = 65536;
      if (v < -65536) v = -65536;
      return v[17:0];
   endfunction

   // Expected sine and cosine word for one angle
   function automatic sincos_word_type predict_sincos(logic [31:0] angle);
      sincos_word_type w;
      logic [63:0]  prod;
      logic [63:0]  scaled;
      logic [63:0]  point;
      logic [63:0]  mag;
      logic [63:0]  dmag;
      logic [63:0]  d2h;
      logic [63:0]  den;
      longint       resid;
      longint       d;
      longint       ts;
      longint       tc;
      prod   = {{32{angle[31]}}, angle} * turn_scale;
      scaled = {40'd0, prod[63:40]} * 64'(N_INTERVALS);
      point  = (scaled + (64'd1 << 23)) >> 24;
      resid  = longint'(scaled) - longint'(point << 24);
      mag    = (resid < 0) ? 64'(-resid) : 64'(resid);
      den    = 64'(N_INTERVALS) << 24;
      dmag   = (mag * two_pi_q30 + (den >> 1)) / den;
      d      = (resid < 0) ? -longint'(dmag) : longint'(dmag);
      d2h    = (dmag * dmag) >> 31;
      ts     = sin_q30[point];
      tc     = cos_q30[point];
      w.angle   = angle;
      w.sin_q16 = q60_to_q16(ts * Q30_UNIT + d * tc - longint'(d2h) * ts);
      w.cos_q16 = q60_to_q16(tc * Q30_UNIT - d * ts - longint'(d2h) * tc);
      return w;
   endfunction

   // Angle in Q8.24 radians for a number of turns, rounded to nearest
   function automatic logic [31:0] angle_of_turns(real turns);
      real r;
      r = turns * TWO_PI_REAL * 16777216.0;
      return 32'($rtoi(r + ((r >= 0.0) ? 0.5 : -0.5)));
   endfunction

   task automatic report_mismatch(string field, logic [31:0] angle, logic [63:0] got,
                                  logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("MISMATCH %s: angle=%h got=%h want=%h", field, angle, got, want);
   endtask

   // Send one angle word, with random idle cycles ahead of it
   task automatic send_angle(logic [31:0] angle);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= angle;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_sincos(angle));
      angles_sent++;
   endtask

   // Hold off the sender until every pending result has arrived
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Field extremes, sign boundary and large angles
   task automatic test_corner_angles();
      logic [31:0] corners [9];
      corners = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h0080_0000, 32'hFF80_0000, 32'h5555_5555,
                  32'hAAAA_AAAA};
      foreach (corners[i]) send_angle(corners[i]);
   endtask

   // Table points, half-way points, quadrants, and the point at a full turn
   task automatic test_table_points();
      real turns [15];
      turns = '{0.25, 0.5, 0.75, 1.0, -0.25, 1.0 / 64.0, 15.0 / 64.0, 17.0 / 64.0,
                15.5 / 64.0, 16.5 / 64.0, 32.5 / 64.0, 48.5 / 64.0, 63.5 / 64.0,
                63.49 / 64.0, 63.51 / 64.0};
      foreach (turns[i]) send_angle(angle_of_turns(turns[i]));
   endtask

   // Mix of full-range words, angles near table points and small angles
   task automatic test_random_angles(int count, int send_pct, int rsp_pct);
      int          sel;
      int          point;
      int          wraps;
      logic [31:0] angle;
      logic [27:0] low;
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 9);
         if (sel < 4) begin
            angle = $urandom();
         end else if (sel < 7) begin
            point = $urandom_range(0, N_INTERVALS);
            wraps = int'($urandom_range(0, 8)) - 4;
            angle = angle_of_turns((real'(point) + 0.5 * real'($urandom_range(0, 1)))
                                   / 64.0 + real'(wraps));
            angle = angle + 32'(int'($urandom_range(0, 64)) - 32);
         end else begin
            low   = 28'($urandom());
            angle = {{4{low[27]}}, low};
         end
         send_angle(angle);
      end
   endtask

   // Receiver backpressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // Compare each result word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected word", 32'd0, 64'(rsp_tdata), 64'd0);
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_tdata[17:0] !== oldest.sin_q16)
               report_mismatch("sin_value", oldest.angle, 64'(rsp_tdata[17:0]),
                               64'(oldest.sin_q16));
            if (rsp_tdata[35:18] !== oldest.cos_q16)
               report_mismatch("cos_value", oldest.angle, 64'(rsp_tdata[35:18]),
                               64'(oldest.cos_q16));
            if (rsp_tdata[sct_pkg::RSP_DATA_W-1:36] !== '0)
               report_mismatch("pad bits", oldest.angle,
                               64'(rsp_tdata[sct_pkg::RSP_DATA_W-1:36]), 64'd0);
         end
      end
   end

   // Watchdog: end the run when no word moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no word accepted for %0d cycles", IDLE_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [63:0]     m;
      logic [63:0]     quad;
      logic [63:0]     rem;
      logic [63:0]     a;
      longint          qs;
      longint          qc;
      sincos_word_type left_over;

      // Predictor constants and tables over the full turn
      turn_scale  = (floor_ratio(ONE_E18, TWO_PI_E18, 41) + 64'd1) >> 1;
      two_pi_q30  = (floor_ratio(TWO_PI_E18, ONE_E18, 31) + 64'd1) >> 1;
      half_pi_q30 = (floor_ratio(TWO_PI_E18, 64'd4 * ONE_E18, 31) + 64'd1) >> 1;
      for (int i = 0; i <= N_INTERVALS; i++) begin
         m    = 64'd4 * 64'(i);
         quad = (m / 64'(N_INTERVALS)) & 64'd3;
         rem  = m % 64'(N_INTERVALS);
         a    = (rem * half_pi_q30 + 64'(N_INTERVALS / 2)) / 64'(N_INTERVALS);
         quarter_sincos(a, qs, qc);
         case (quad[1:0])
            2'd0: begin
               sin_q30[i] = qs;
               cos_q30[i] = qc;
            end
            2'd1: begin
               sin_q30[i] = qc;
               cos_q30[i] = -qs;
            end
            2'd2: begin
               sin_q30[i] = -qs;
               cos_q30[i] = -qc;
            end
            default: begin
               sin_q30[i] = -qc;
               cos_q30[i] = qs;
            end
         endcase
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_angles();
      test_table_points();
      drain_results();
      test_random_angles(RANDOM_ITEMS, 25, 60);
      test_random_angles(RANDOM_ITEMS, 60, 25);
      test_random_angles(RANDOM_ITEMS, 0, 0);

      // Let the pipeline empty, then wait out TAIL_CYCLES before the final check
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      while (pending_results.size() != 0) begin
         left_over = pending_results.pop_front();
         report_mismatch("missing word", left_over.angle, 64'd0, 64'(left_over.sin_q16));
      end

      $display("Ran %0d angles (directed corners, table and half points, random mix)",
               angles_sent);
      $display("Checked %0d result words under three idle and stall mixes, %0d mismatches",
               results_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+design
design/sct_pkg.sv
design/sct_turn.sv
design/sct_resid.sv
design/sct_taylor.sv
design/sincos_lut_taylor.sv
sim/tb.sv
